/* design/kseq_pkg.sv */
// ----------------------------------------------------------------------------
// kseq_pkg
// Shared types and constants of the keypad scan and event queue block.
// ----------------------------------------------------------------------------
package kseq_pkg;

  localparam int unsigned KeyCount = 20;
  localparam int unsigned KeyW     = 5;
  localparam int unsigned RowBits  = 4;
  // row probed by the column-pair readings
  localparam int unsigned PairRow  = 2;
  localparam int unsigned BtnBase  = 16;

  typedef logic [KeyCount-1:0] key_vec_t;

  // one queued event: direction and raw key number
  typedef struct packed {
    logic            pressed;
    logic [KeyW-1:0] index;
  } event_t;

  // queue command from the sequencer
  typedef struct packed {
    logic push;
    logic pop;
  } q_ctrl_t;

  // keypad legend, row r / column c -> key number
  function automatic logic [3:0] key_at(input logic [1:0] r, input logic [1:0] c);
    logic [3:0] k;
    unique case ({r, c})
      4'h0: k = 4'h1;  4'h1: k = 4'h2;  4'h2: k = 4'h3;  4'h3: k = 4'hA;
      4'h4: k = 4'h4;  4'h5: k = 4'h5;  4'h6: k = 4'h6;  4'h7: k = 4'hB;
      4'h8: k = 4'h7;  4'h9: k = 4'h8;  4'hA: k = 4'h9;  4'hB: k = 4'hC;
      4'hC: k = 4'h0;  4'hD: k = 4'hF;  4'hE: k = 4'hE;  default: k = 4'hD;
    endcase
    return k;
  endfunction

endpackage

/* design/kseq_scan.sv */
// ----------------------------------------------------------------------------
// kseq_scan
// Decodes one scan frame into the 20-bit key vector.
// ----------------------------------------------------------------------------
module kseq_scan import kseq_pkg::*; (
  input  logic [RowBits-1:0] col0_rows_i,
  input  logic [RowBits-1:0] col1_rows_i,
  input  logic [RowBits-1:0] col2_rows_i,
  input  logic [RowBits-1:0] col3_rows_i,
  input  logic [RowBits-1:0] pair23_rows_i,
  input  logic [RowBits-1:0] pair12_rows_i,
  input  logic [3:0]         buttons_i,
  output key_vec_t           keys_o
);

  logic [3:0][RowBits-1:0] cols;
  logic [15:0]             pad_hits;
  logic                    any_hit;

  assign cols = {col3_rows_i, col2_rows_i, col1_rows_i, col0_rows_i};

  always_comb begin
    pad_hits = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (!cols[c][r]) begin
          pad_hits[key_at(2'(r), 2'(c))] = 1'b1;
        end
      end
    end
  end

  assign any_hit = (cols != '1);

  always_comb begin
    keys_o = {4'b0, pad_hits};
    // same-row double press only shows on the pair probes
    if (!any_hit) begin
      if (!pair23_rows_i[PairRow]) begin
        keys_o[4'hC] = 1'b1;
        keys_o[4'h9] = 1'b1;
      end
      if (!pair12_rows_i[PairRow]) begin
        keys_o[4'h8] = 1'b1;
        keys_o[4'h9] = 1'b1;
      end
    end
    // highest set button wins
    if (buttons_i != '0) begin
      priority if (buttons_i[3]) keys_o[BtnBase+3] = 1'b1;
      else if (buttons_i[2])     keys_o[BtnBase+2] = 1'b1;
      else if (buttons_i[1])     keys_o[BtnBase+1] = 1'b1;
      else                       keys_o[BtnBase]   = 1'b1;
    end
  end

endmodule

/* design/kseq_queue.sv */
// ----------------------------------------------------------------------------
// kseq_queue
// Event FIFO: one-entry-free full rule, drop on full, sticky overflow.
// ----------------------------------------------------------------------------
module kseq_queue import kseq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 16,
  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
  localparam int unsigned FillW = PtrW + 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  q_ctrl_t          ctrl_i,
  input  event_t           wr_entry_i,
  output event_t           rd_entry_o,
  output logic [FillW-1:0] fill_o,
  output logic             overflow_o
);

  localparam logic [PtrW-1:0]  LastPtr = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [FillW-1:0] FullFill = FillW'(QUEUE_DEPTH - 1);

  event_t           mem [QUEUE_DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [FillW-1:0] fill_q;
  logic             ovf_q;
  logic             full;
  logic             do_push;

  assign full    = (fill_q == FullFill);
  assign do_push = ctrl_i.push && !full;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_ptr_q] <= wr_entry_i;
    end
    if (ctrl_i.pop) begin
      rd_entry_o <= mem[rd_ptr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
      ovf_q    <= 1'b0;
    end else begin
      if (ctrl_i.push && full) begin
        ovf_q <= 1'b1;
      end
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
        fill_q   <= fill_q + 1'b1;
      end else if (ctrl_i.pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
        fill_q   <= fill_q - 1'b1;
      end
    end
  end

  assign fill_o     = fill_q;
  assign overflow_o = ovf_q;

endmodule

/* design/keypad_scan_event_queue_core.sv */
// ----------------------------------------------------------------------------
// keypad_scan_event_queue_core
// Keypad scan frames in, key press/release events queued and popped.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis): tuser = command (0 scan frame, 1 pop one event),
//   tdata = the six row readings and the button word. Every input transfer
//   yields exactly one output transfer on m_axis.
//   Scan frame: the frame is decoded to a 20-key vector in the accept cycle,
//   then a single bit walker visits key 0..19, one key per cycle, and pushes
//   an event for each key that changed; after key 19 the result is offered.
//   Pop: the queue is checked in the pop state; a non-empty queue goes through
//   a read state (queue memory read is registered) before the result is offered.
//   One item is in flight at a time; s_axis_tready_o is low from accept
//   until the result transfer completes, so a new item is taken only after
//   the receiver has taken the last result.
//   Receiver stall: the result is held in registers until m_axis_tready_i.
//   Reset: key history, pointers, fill count and overflow flag clear; queue
//   memory contents are not cleared (never read before being written).
// ----------------------------------------------------------------------------
module keypad_scan_event_queue_core import kseq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // s_axis: command
  input  logic        s_axis_tuser_i,
  // s_axis: col0_rows[3:0], col1_rows[7:4], col2_rows[11:8], col3_rows[15:12],
  //         pair23_rows[19:16], pair12_rows[23:20], buttons[27:24], zero pad
  input  logic [31:0] s_axis_tdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // m_axis: event_valid
  output logic        m_axis_tuser_o,
  // m_axis: key_pressed[0], key_index[5:1], queued_count[9:6], overflow[10],
  //         zero pad
  output logic [15:0] m_axis_tdata_o,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i
);

  localparam int unsigned PtrW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned FillW = PtrW + 1;
  localparam logic [KeyW-1:0] LastKey = KeyW'(KeyCount - 1);
  localparam logic [FillW+3:0] CountSat = (FillW+4)'(15);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SCAN = 5'b00010,
    ST_POP  = 5'b00100,
    ST_RD   = 5'b01000,
    ST_OUT  = 5'b10000
  } state_e;

  state_e           state_q, state_d;
  key_vec_t         now_q, prev_q, scan_keys;
  logic [KeyW-1:0]  key_q;
  logic             res_valid_q;
  logic             res_pressed_q;
  logic [KeyW-1:0]  res_index_q;
  q_ctrl_t          q_ctrl;
  event_t           q_wr, q_rd;
  logic [FillW-1:0] q_fill;
  logic             q_ovf;
  logic [3:0]       queued_count;
  logic             in_xfer, out_xfer;

  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_xfer = m_axis_tvalid_o && m_axis_tready_i;

  kseq_scan u_scan (
    .col0_rows_i   (s_axis_tdata_i[3:0]),
    .col1_rows_i   (s_axis_tdata_i[7:4]),
    .col2_rows_i   (s_axis_tdata_i[11:8]),
    .col3_rows_i   (s_axis_tdata_i[15:12]),
    .pair23_rows_i (s_axis_tdata_i[19:16]),
    .pair12_rows_i (s_axis_tdata_i[23:20]),
    .buttons_i     (s_axis_tdata_i[27:24]),
    .keys_o        (scan_keys)
  );

  kseq_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (q_ctrl),
    .wr_entry_i (q_wr),
    .rd_entry_o (q_rd),
    .fill_o     (q_fill),
    .overflow_o (q_ovf)
  );

  // Walker compares one key of the new and old vectors per cycle.
  assign q_wr.pressed = now_q[key_q];
  assign q_wr.index   = key_q;

  always_comb begin
    q_ctrl.push = (state_q == ST_SCAN) && (now_q[key_q] != prev_q[key_q]);
    q_ctrl.pop  = (state_q == ST_POP) && (q_fill != '0);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) state_d = s_axis_tuser_i ? ST_POP : ST_SCAN;
      end
      ST_SCAN: begin
        if (key_q == LastKey) state_d = ST_OUT;
      end
      ST_POP: begin
        state_d = (q_fill != '0) ? ST_RD : ST_OUT;
      end
      ST_RD: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_xfer) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      prev_q  <= '0;
      key_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_IDLE) begin
        key_q <= '0;
      end else if (state_q == ST_SCAN) begin
        key_q <= key_q + 1'b1;
        if (key_q == LastKey) prev_q <= now_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      now_q         <= scan_keys;
      res_valid_q   <= 1'b0;
      res_pressed_q <= 1'b0;
      res_index_q   <= '0;
    end else if (state_q == ST_RD) begin
      res_valid_q   <= 1'b1;
      res_pressed_q <= q_rd.pressed;
      res_index_q   <= q_rd.index;
    end
  end

  assign queued_count = ((FillW+4)'(q_fill) > CountSat) ? 4'd15 : 4'(q_fill);

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = (state_q == ST_OUT);
  assign m_axis_tuser_o  = res_valid_q;
  assign m_axis_tdata_o  = {5'b0, q_ovf, queued_count, res_index_q, res_pressed_q};

  // ---------------------------------------------------------------- checks
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !s_axis_tready_o)
    else $error("input ready while a result is pending");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (FillW+4)'(q_fill) < (FillW+4)'(QUEUE_DEPTH))
    else $error("queue fill beyond capacity");

  a_valid_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tdata_o[5:1] <= LastKey))
    else $error("popped key number out of range");

  a_no_push_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_ctrl.push && q_ctrl.pop))
    else $error("push and pop in the same cycle");

  a_ovf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(q_ovf) |-> q_ovf)
    else $error("overflow flag cleared without reset");

endmodule

/* tb/keypad_scan_event_queue_core_test.sv */
// ----------------------------------------------------------------------------
// keypad_scan_event_queue_core_test
// Self-checking bench: scan frames and pops go in on s_axis, every result on
// m_axis is matched against a typed result or a behavioral model of the key decode and queue.
// ----------------------------------------------------------------------------
module keypad_scan_event_queue_core_test;
  import kseq_pkg::*;

  localparam int unsigned QDEPTH       = 16;
  localparam int unsigned RANDOM_ITEMS = 440;
  localparam int unsigned CYCLE_LIMIT  = 200_000;
  // longest item is a scan; drain covers it plus margin
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned HOLD_AFTER   = 150;

  // keypad legend, nibble (r*4 + c) holds the key at row r, column c
  localparam logic [63:0] KEY_LEGEND = 64'hDEF0_C987_B654_A321;

  typedef enum logic {
    CMD_SCAN = 1'b0,
    CMD_POP  = 1'b1
  } command_e;

  // scan frame as it sits in tdata[27:0], col0 in the low nibble
  typedef struct packed {
    logic [3:0] buttons;
    logic [3:0] pair12;
    logic [3:0] pair23;
    logic [3:0] col3;
    logic [3:0] col2;
    logic [3:0] col1;
    logic [3:0] col0;
  } frame_t;

  typedef struct packed {
    logic            valid;
    logic            pressed;
    logic [KeyW-1:0] index;
    logic [3:0]      count;
    logic            overflow;
  } report_t;

  typedef struct packed {
    command_e cmd;
    frame_t   frame;
    logic     known;
    report_t  typed;
  } stim_row_t;

  // all rows released, no probe hit, no button
  localparam frame_t IDLE_FRAME = 28'h0FF_FFFF;

  // Directed rows. Typed results only where obvious; the rest go through
  // the model. Covers both pair probes, pair probes masked by a single hit,
  // each button bit alone and all at once, and finally a frame with all pad
  // keys pressed that overruns the queue (sticky overflow from then on).
  localparam int unsigned DIR_ROWS = 22;
  localparam stim_row_t DIRECTED [DIR_ROWS] = '{
    '{CMD_POP,  IDLE_FRAME,    1'b1, '{1'b0, 1'b0, 5'd0, 4'd0, 1'b0}}, // pop, empty
    '{CMD_SCAN, IDLE_FRAME,    1'b1, '{1'b0, 1'b0, 5'd0, 4'd0, 1'b0}}, // no change
    '{CMD_SCAN, 28'h0FF_FFFE,  1'b1, '{1'b0, 1'b0, 5'd0, 4'd1, 1'b0}}, // key 1 down
    '{CMD_POP,  IDLE_FRAME,    1'b1, '{1'b1, 1'b1, 5'd1, 4'd0, 1'b0}},
    '{CMD_SCAN, 28'h0FB_FFFF,  1'b0, '0},  // pair 2/3 probe only
    '{CMD_SCAN, 28'h0BF_FFFF,  1'b0, '0},  // pair 1/2 probe only
    '{CMD_SCAN, 28'h0BB_7FFF,  1'b0, '0},  // probes ignored, single hit key D
    '{CMD_SCAN, 28'hFFF_FFFF,  1'b0, '0},  // all buttons, top one wins
    '{CMD_SCAN, 28'h1FF_FFFF,  1'b0, '0},
    '{CMD_POP,  IDLE_FRAME,    1'b0, '0},
    '{CMD_POP,  IDLE_FRAME,    1'b0, '0},
    '{CMD_POP,  IDLE_FRAME,    1'b0, '0},
    '{CMD_POP,  IDLE_FRAME,    1'b0, '0},
    '{CMD_SCAN, 28'h2FF_FFFF,  1'b0, '0},
    '{CMD_SCAN, 28'h4FF_FFFF,  1'b0, '0},
    '{CMD_SCAN, 28'h8FF_FFFF,  1'b0, '0},
    '{CMD_SCAN, 28'h000_0000,  1'b0, '0},  // every pad key down: queue overruns
    '{CMD_SCAN, 28'hFFF_FFFF,  1'b0, '0},  // pad keys released, top button down, while still full
    '{CMD_POP,  IDLE_FRAME,    1'b0, '0},
    '{CMD_POP,  IDLE_FRAME,    1'b0, '0},
    '{CMD_POP,  IDLE_FRAME,    1'b0, '0},
    '{CMD_POP,  IDLE_FRAME,    1'b0, '0}
  };

  logic        clk_i;
  logic        rst_ni     = 1'b0;
  logic        s_tuser    = 1'b0;
  logic [31:0] s_tdata    = '0;
  logic        s_tvalid   = 1'b0;
  logic        m_tready   = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tuser_o;
  logic [15:0] m_axis_tdata_o;
  logic        m_axis_tvalid_o;

  keypad_scan_event_queue_core #(
    .QUEUE_DEPTH (QDEPTH)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Model of the block: key history and event queue, same reset as the RTL.
  // --------------------------------------------------------------------------
  key_vec_t    key_history = '0;
  event_t      event_ring [QDEPTH];
  int unsigned ring_wr     = 0;
  int unsigned ring_rd     = 0;
  logic        events_lost = 1'b0;

  report_t     awaited_reports [$];
  int unsigned failures        = 0;
  int unsigned reports_checked = 0;
  int unsigned cycle_count     = 0;

  // sender burst state
  int unsigned burst_left = 0;
  logic        valid_low  = 1'b1;

  function automatic int unsigned ring_fill();
    return (ring_wr + QDEPTH - ring_rd) % QDEPTH;
  endfunction

  // frame -> 20-key vector
  function automatic key_vec_t decode_frame(input frame_t f);
    key_vec_t   keys;
    logic [3:0] col_rows [4];
    logic       any_hit;
    int         top_button;
    keys = '0;
    any_hit = 1'b0;
    top_button = -1;
    col_rows[0] = f.col0;
    col_rows[1] = f.col1;
    col_rows[2] = f.col2;
    col_rows[3] = f.col3;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (!col_rows[c][r]) begin
          keys[KEY_LEGEND[(r * 4 + c) * 4 +: 4]] = 1'b1;
          any_hit = 1'b1;
        end
      end
    end
    // pair probes on the shared row: 2/3 -> keys 9 and C, 1/2 -> keys 8 and 9
    if (!any_hit) begin
      if (!f.pair23[PairRow]) begin
        keys[4'hC] = 1'b1;
        keys[4'h9] = 1'b1;
      end
      if (!f.pair12[PairRow]) begin
        keys[4'h8] = 1'b1;
        keys[4'h9] = 1'b1;
      end
    end
    for (int j = 0; j < 4; j++) begin
      if (f.buttons[j]) top_button = j;
    end
    if (top_button >= 0) keys[BtnBase + top_button] = 1'b1;
    return keys;
  endfunction

  // advance the model by one item, return the result it must produce
  function automatic report_t predict_report(input command_e cmd, input frame_t f);
    report_t     rep;
    key_vec_t    now_keys;
    key_vec_t    changed;
    event_t      ev;
    int unsigned fill;
    rep = '0;
    if (cmd == CMD_SCAN) begin
      now_keys = decode_frame(f);
      changed  = now_keys ^ key_history;
      for (int k = 0; k < KeyCount; k++) begin
        if (changed[k]) begin
          ev.pressed = now_keys[k];
          ev.index   = KeyW'(k);
          // one slot stays free: equal pointers mean empty
          if (ring_fill() >= QDEPTH - 1) begin
            events_lost = 1'b1;
          end else begin
            event_ring[ring_wr] = ev;
            ring_wr = (ring_wr + 1) % QDEPTH;
          end
        end
      end
      key_history = now_keys;
    end else if (ring_rd != ring_wr) begin
      ev = event_ring[ring_rd];
      ring_rd = (ring_rd + 1) % QDEPTH;
      rep.valid   = 1'b1;
      rep.pressed = ev.pressed;
      rep.index   = ev.index;
    end
    fill = ring_fill();
    rep.count    = (fill > 15) ? 4'd15 : 4'(fill);
    rep.overflow = events_lost;
    return rep;
  endfunction

  // --------------------------------------------------------------------------
  // Sender: offers one item, waits for the transfer, records the expectation,
  // then maybe takes a gap at the end of a burst.
  // --------------------------------------------------------------------------
  task automatic send_item(input command_e cmd, input frame_t f, input logic known,
                           input report_t typed);
    report_t     predicted;
    int unsigned gap;
    s_tvalid  <= 1'b1;
    s_tuser   <= cmd;
    s_tdata   <= {4'h0, f};
    valid_low  = 1'b0;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predicted = predict_report(cmd, f);
    awaited_reports.push_back(known ? typed : predicted);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      // a quarter of the bursts run straight into the next one
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        s_tvalid  <= 1'b0;
        valid_low  = 1'b1;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  initial begin : stimulus
    frame_t      f;
    frame_t      last_scan;
    int unsigned pick;
    int unsigned hits;
    last_scan = IDLE_FRAME;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_item(DIRECTED[i].cmd, DIRECTED[i].frame, DIRECTED[i].known, DIRECTED[i].typed);
    end

    // Random part: mostly plausible keypad traffic (up to two pad keys held, held
    // frames repeated, probes and buttons toggling) mixed with pops to keep
    // the queue moving, plus some raw noise frames.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        send_item(CMD_POP, frame_t'($urandom & 32'h0FFF_FFFF), 1'b0, '0);
      end else if (pick < 60) begin
        send_item(CMD_SCAN, last_scan, 1'b0, '0);
      end else if (pick < 90) begin
        f = IDLE_FRAME;
        hits = $urandom_range(0, 2);
        repeat (hits) f[$urandom_range(0, 15)] = 1'b0;
        f.pair23 = 4'($urandom);
        f.pair12 = 4'($urandom);
        if ($urandom_range(0, 1)) f.pair23[PairRow] = 1'b1;
        if ($urandom_range(0, 1)) f.pair12[PairRow] = 1'b1;
        f.buttons = $urandom_range(0, 1) ? 4'h0 : 4'($urandom);
        last_scan = f;
        send_item(CMD_SCAN, f, 1'b0, '0);
      end else begin
        f = frame_t'($urandom & 32'h0FFF_FFFF);
        last_scan = f;
        send_item(CMD_SCAN, f, 1'b0, '0);
      end
    end
    if (!valid_low) s_tvalid <= 1'b0;

    while (awaited_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (failures == 0) begin
      $display("PASS keypad_scan_event_queue_core");
    end else begin
      $display("FAIL keypad_scan_event_queue_core");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: picks a new stall pattern for each phase of random length; once, after a
  // number of results, it holds off long enough to back up the input side.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int unsigned phase_left;
    int unsigned mode;
    logic        hold_done;
    phase_left = 0;
    mode = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!hold_done && reports_checked >= HOLD_AFTER) begin
        hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else begin
        if (phase_left == 0) begin
          mode = $urandom_range(0, 3);
          phase_left = $urandom_range(16, 80);
        end
        phase_left--;
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= ($urandom_range(0, 9) < 7);
          2: m_tready <= ($urandom_range(0, 9) < 3);
          default: m_tready <= (cycle_count % 5 != 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checker
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input int unsigned exp_val,
                             input int unsigned got_val);
    if (exp_val != got_val) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val, got_val);
      failures++;
    end
  endtask

  always @(posedge clk_i) begin
    report_t exp_rep;
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      if (awaited_reports.size() == 0) begin
        $display("%0t: unexpected result, expected none, got tuser %0b tdata %h",
                 $time, m_axis_tuser_o, m_axis_tdata_o);
        failures++;
      end else begin
        exp_rep = awaited_reports.pop_front();
        check_field("event_valid",  32'(exp_rep.valid),    32'(m_axis_tuser_o));
        check_field("key_pressed",  32'(exp_rep.pressed),  32'(m_axis_tdata_o[0]));
        check_field("key_index",    32'(exp_rep.index),    32'(m_axis_tdata_o[5:1]));
        check_field("queued_count", 32'(exp_rep.count),    32'(m_axis_tdata_o[9:6]));
        check_field("overflow",     32'(exp_rep.overflow), 32'(m_axis_tdata_o[10]));
        reports_checked++;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL keypad_scan_event_queue_core");
      $finish;
    end
  end

endmodule
